// ===== hw/rtl/onht_pkg.sv =====
// Types, command and status codes, and key normalisation for the ordered
// name-to-handle table. No dependencies.
package onht_pkg;

  localparam int KEY_BYTES = 19;
  localparam int KEY_W     = 8 * KEY_BYTES;
  localparam int HANDLE_W  = 16;

  typedef logic [KEY_W-1:0]    key_t;
  typedef logic [HANDLE_W-1:0] handle_t;

  typedef struct packed {
    key_t    key;
    handle_t handle;
  } record_t;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;

  // Zero every byte after the first zero byte of the name.
  function automatic key_t clean_key(input key_t raw);
    logic ended;
    key_t k;
    ended = 1'b0;
    k     = raw;
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (ended) begin
        k[8*i +: 8] = 8'h00;
      end else if (raw[8*i +: 8] == 8'h00) begin
        ended = 1'b1;
      end
    end
    return k;
  endfunction

endpackage

// ===== hw/rtl/ordered_name_to_handle_table.sv =====
// Ordered name-to-handle table: record memory, scan and compaction sequencer.
// Depends on onht_pkg.
//
// Usage: one request on the in_ channel (command, 19-byte name key, handle)
// gives exactly one result on the out_ channel (status, handle, position,
// entry count after the request). Both channels use valid/stall handshakes.
// Records live in a single-port-write, registered-read memory that one
// sequencer walks one entry a cycle; the same read port serves lookup,
// remove and the shift-down after a remove, and one key comparator serves
// lookup and remove. Insert and an unused command go straight to the
// result; lookup scans from index 0 to the first match or to the entry
// count, and remove scans the same way, then on a match moves every later
// record one place down. in_stall stays high from acceptance until the result
// is loaded into the output register, so a new request is taken while a
// result waits. If the receiver stalls, the result holds in the output
// register and a finished request waits in the finish state until that
// register is free. Reset empties the table (entry count zero) and clears
// the output valid flag; record contents are not cleared and need no
// clearing pass.
module ordered_name_to_handle_table #(
  parameter int MAX_ENTRIES = 128
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             in_command,
  input  logic [63:0]            in_key_bytes_low,
  input  logic [63:0]            in_key_bytes_mid,
  input  logic [23:0]            in_key_bytes_high,
  input  onht_pkg::handle_t      in_handle_in,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             out_status,
  output onht_pkg::handle_t      out_handle_out,
  output logic [6:0]             out_position,
  output logic [7:0]             out_entry_count
);
  import onht_pkg::*;

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_ENTRIES);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_SHIFT, S_FINISH} state_t;

  state_t           state_r, state_nxt;
  logic [1:0]       cmd_r, cmd_nxt;
  key_t             key_r, key_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] sidx_r, sidx_nxt;
  logic             chk_v_r, chk_v_nxt;
  logic [IDX_W-1:0] chk_idx_r, chk_idx_nxt;
  logic [1:0]       res_status_r, res_status_nxt;
  handle_t          res_handle_r, res_handle_nxt;
  logic [IDX_W-1:0] res_pos_r, res_pos_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_status_r, out_status_nxt;
  handle_t          out_handle_r, out_handle_nxt;
  logic [6:0]       out_pos_r, out_pos_nxt;
  logic [7:0]       out_cnt_r, out_cnt_nxt;

  record_t          mem [MAX_ENTRIES];
  record_t          rd_data_r;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [IDX_W-1:0] mem_raddr;
  record_t          mem_wdata;

  key_t             in_key_clean;
  logic             accept;
  logic             hit;
  logic [IDX_W+6:0] pos_ext;
  logic [CNT_W+7:0] cnt_ext;

  assign in_key_clean = clean_key({in_key_bytes_high, in_key_bytes_mid, in_key_bytes_low});
  assign in_stall     = (state_r != S_IDLE);
  assign accept       = in_valid && (state_r == S_IDLE);
  assign hit          = chk_v_r && (rd_data_r.key == key_r);
  assign pos_ext      = {7'b0, res_pos_r};
  assign cnt_ext      = {8'b0, count_r};

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    count_nxt      = count_r;
    sidx_nxt       = sidx_r;
    chk_v_nxt      = 1'b0;
    chk_idx_nxt    = sidx_r[IDX_W-1:0];
    res_status_nxt = res_status_r;
    res_handle_nxt = res_handle_r;
    res_pos_nxt    = res_pos_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_handle_nxt = out_handle_r;
    out_pos_nxt    = out_pos_r;
    out_cnt_nxt    = out_cnt_r;
    mem_we         = 1'b0;
    mem_waddr      = count_r[IDX_W-1:0];
    mem_wdata      = '{key: in_key_clean, handle: in_handle_in};
    mem_raddr      = sidx_r[IDX_W-1:0];

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt        = in_command;
          key_nxt        = in_key_clean;
          sidx_nxt       = '0;
          res_status_nxt = ST_OK;
          res_handle_nxt = '0;
          res_pos_nxt    = '0;
          case (in_command)
            CMD_INSERT: begin
              if (count_r == FULL_CNT) begin
                res_status_nxt = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                count_nxt = count_r + 1'b1;
              end
              state_nxt = S_FINISH;
            end
            CMD_LOOKUP, CMD_REMOVE: begin
              state_nxt = S_SCAN;
            end
            default: begin
              state_nxt = S_FINISH;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (hit) begin
          res_pos_nxt = chk_idx_r;
          if (cmd_r == CMD_LOOKUP) begin
            res_handle_nxt = rd_data_r.handle;
            state_nxt      = S_FINISH;
          end else begin
            // start compaction with the record after the match
            sidx_nxt  = CNT_W'(chk_idx_r) + 1'b1;
            state_nxt = S_SHIFT;
          end
        end else if (!chk_v_r && sidx_r == count_r) begin
          res_status_nxt = ST_ABSENT;
          state_nxt      = S_FINISH;
        end else if (sidx_r < count_r) begin
          chk_v_nxt = 1'b1;
          sidx_nxt  = sidx_r + 1'b1;
        end
      end

      S_SHIFT: begin
        // write the record read last cycle one place lower
        if (chk_v_r) begin
          mem_we    = 1'b1;
          mem_waddr = chk_idx_r - 1'b1;
          mem_wdata = rd_data_r;
        end
        if (sidx_r < count_r) begin
          chk_v_nxt = 1'b1;
          sidx_nxt  = sidx_r + 1'b1;
        end else if (!chk_v_r) begin
          count_nxt = count_r - 1'b1;
          state_nxt = S_FINISH;
        end
      end

      S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_handle_nxt = res_handle_r;
          out_pos_nxt    = pos_ext[6:0];
          out_cnt_nxt    = cnt_ext[7:0];
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      chk_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      chk_v_r     <= chk_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    sidx_r       <= sidx_nxt;
    chk_idx_r    <= chk_idx_nxt;
    res_status_r <= res_status_nxt;
    res_handle_r <= res_handle_nxt;
    res_pos_r    <= res_pos_nxt;
    out_status_r <= out_status_nxt;
    out_handle_r <= out_handle_nxt;
    out_pos_r    <= out_pos_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_handle_out  = out_handle_r;
  assign out_position    = out_pos_r;
  assign out_entry_count = out_cnt_r;

endmodule

// ===== hw/rtl/onht_checker.sv =====
// Port-level checks for the ordered name-to-handle table, and the bind that
// attaches them to the top level. Depends on onht_pkg.
module onht_checker #(
  parameter int MAX_ENTRIES = 128
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [1:0]        out_status,
  input onht_pkg::handle_t out_handle_out,
  input logic [6:0]        out_position,
  input logic [7:0]        out_entry_count
);
  import onht_pkg::*;

  localparam logic [7:0] FULL_CNT = 8'(MAX_ENTRIES);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_handle_out) && $stable(out_position) && $stable(out_entry_count))
    else $error("stalled result changed");

  // one request at a time: busy right after acceptance
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while busy");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_entry_count == FULL_CNT)
    else $error("full status with table not full");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_ABSENT |-> out_handle_out == '0 && out_position == '0)
    else $error("absent name with non-zero handle or position");

  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind ordered_name_to_handle_table onht_checker #(.MAX_ENTRIES(MAX_ENTRIES)) u_onht_checker (.*);

// ===== tb/onht_reply_checker.sv =====
// Reply checker for the ordered name-to-handle table: mirrors the record list,
// predicts one reply per accepted request and compares replies in order.
// Depends on onht_pkg.
module onht_reply_checker #(
  parameter int DEPTH = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [1:0]        in_command,
  input  logic [63:0]       in_key_bytes_low,
  input  logic [63:0]       in_key_bytes_mid,
  input  logic [23:0]       in_key_bytes_high,
  input  onht_pkg::handle_t in_handle_in,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [1:0]        out_status,
  input  onht_pkg::handle_t out_handle_out,
  input  logic [6:0]        out_position,
  input  logic [7:0]        out_entry_count,
  output int                fail_count,
  output int                outstanding,
  output int                full_replies,
  output int                absent_replies,
  output int                peak_fill
);
  timeunit 1ns;
  timeprecision 1ps;
  import onht_pkg::*;

  typedef struct packed {
    logic [1:0] status;
    handle_t    handle;
    logic [6:0] position;
    logic [7:0] count;
  } reply_t;

  key_t    table_names   [DEPTH];
  handle_t table_handles [DEPTH];
  int      held    = 0;
  int      errs    = 0;
  int      fulls   = 0;
  int      absents = 0;
  int      peak    = 0;
  reply_t  pending_replies [$];
  reply_t  want;

  // Keep the bytes before the first zero byte, clear the rest.
  function automatic key_t trim_name(key_t raw);
    key_t k;
    int   cut;
    cut = KEY_BYTES;
    for (int b = KEY_BYTES - 1; b >= 0; b--) begin
      if (raw[8*b +: 8] == 8'h00) cut = b;
    end
    k = '0;
    for (int b = 0; b < cut; b++) k[8*b +: 8] = raw[8*b +: 8];
    return k;
  endfunction

  // Update the mirrored table and give the reply this request must produce.
  function automatic reply_t apply_request(logic [1:0] cmd, key_t raw, handle_t h);
    reply_t r;
    key_t   name;
    int     hit;
    r    = '0;
    name = trim_name(raw);
    hit  = -1;
    for (int i = 0; i < held; i++) begin
      if (hit < 0 && table_names[i] == name) hit = i;
    end
    case (cmd)
      CMD_INSERT: begin
        if (held >= DEPTH) begin
          r.status = ST_FULL;
          fulls++;
        end else begin
          table_names[held]   = name;
          table_handles[held] = h;
          held++;
          if (held > peak) peak = held;
        end
      end
      CMD_LOOKUP: begin
        if (hit < 0) begin
          r.status = ST_ABSENT;
          absents++;
        end else begin
          r.handle   = table_handles[hit];
          r.position = 7'(hit);
        end
      end
      CMD_REMOVE: begin
        if (hit < 0) begin
          r.status = ST_ABSENT;
          absents++;
        end else begin
          r.position = 7'(hit);
          // close the gap left by the removed record
          for (int i = hit; i + 1 < held; i++) begin
            table_names[i]   = table_names[i + 1];
            table_handles[i] = table_handles[i + 1];
          end
          held--;
        end
      end
      default: ;
    endcase
    r.count = 8'(held);
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      held = 0;
      pending_replies.delete();
    end else begin
      if (in_valid && !in_stall) begin
        pending_replies.push_back(apply_request(in_command,
            {in_key_bytes_high, in_key_bytes_mid, in_key_bytes_low}, in_handle_in));
      end
      if (out_valid && !out_stall) begin
        if (pending_replies.size() == 0) begin
          $error("reply with no request waiting: status %0d count %0d",
                 out_status, out_entry_count);
          errs++;
        end else begin
          want = pending_replies.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            errs++;
          end
          if (out_handle_out !== want.handle) begin
            $error("handle_out: expected %0h, got %0h", want.handle, out_handle_out);
            errs++;
          end
          if (out_position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, out_position);
            errs++;
          end
          if (out_entry_count !== want.count) begin
            $error("entry_count: expected %0d, got %0d", want.count, out_entry_count);
            errs++;
          end
        end
      end
    end
    fail_count     <= errs;
    outstanding    <= pending_replies.size();
    full_replies   <= fulls;
    absent_replies <= absents;
    peak_fill      <= peak;
  end

endmodule

// ===== tb/tb_ordered_name_to_handle_table.sv =====
// Top of the ordered name-to-handle table bench: clock, reset, request and
// stall stimulus, and the verdict. Depends on onht_pkg, the table RTL and
// onht_reply_checker.
module tb_ordered_name_to_handle_table;
  timeunit 1ns;
  timeprecision 1ps;
  import onht_pkg::*;

  localparam int         TABLE_DEPTH = 128;
  localparam int         POOL_N      = 20;
  localparam int         LONG_HOLD   = 400;
  localparam int         HOLD_AT     = 330;
  localparam logic [1:0] CMD_SPARE   = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_command;
  logic [63:0] in_key_bytes_low;
  logic [63:0] in_key_bytes_mid;
  logic [23:0] in_key_bytes_high;
  handle_t     in_handle_in;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  handle_t     out_handle_out;
  logic [6:0]  out_position;
  logic [7:0]  out_entry_count;

  int   fail_count;
  int   outstanding;
  int   full_replies;
  int   absent_replies;
  int   peak_fill;

  key_t pool_key [POOL_N];
  int   pool_len [POOL_N];
  int   sent_n = 0;
  int   cmd_seen [4];
  bit   quiet     = 1'b0;
  bit   hold_done = 1'b0;

  always #6 clk = ~clk;

  ordered_name_to_handle_table #(
    .MAX_ENTRIES(TABLE_DEPTH)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_key_bytes_low (in_key_bytes_low),
    .in_key_bytes_mid (in_key_bytes_mid),
    .in_key_bytes_high(in_key_bytes_high),
    .in_handle_in     (in_handle_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_handle_out   (out_handle_out),
    .out_position     (out_position),
    .out_entry_count  (out_entry_count)
  );

  onht_reply_checker #(
    .DEPTH(TABLE_DEPTH)
  ) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_key_bytes_low (in_key_bytes_low),
    .in_key_bytes_mid (in_key_bytes_mid),
    .in_key_bytes_high(in_key_bytes_high),
    .in_handle_in     (in_handle_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_handle_out   (out_handle_out),
    .out_position     (out_position),
    .out_entry_count  (out_entry_count),
    .fail_count       (fail_count),
    .outstanding      (outstanding),
    .full_replies     (full_replies),
    .absent_replies   (absent_replies),
    .peak_fill        (peak_fill)
  );

  // Fill every byte after the terminator with junk; the name stays the same.
  function automatic key_t with_garbage(key_t k, int len);
    key_t g;
    g = k;
    for (int b = len + 1; b < KEY_BYTES; b++) g[8*b +: 8] = 8'($urandom);
    return g;
  endfunction

  function automatic key_t pick_name();
    int p;
    p = $urandom_range(0, POOL_N - 1);
    if ($urandom_range(0, 1) == 1) return with_garbage(pool_key[p], pool_len[p]);
    return pool_key[p];
  endfunction

  // Present one request, hold it until taken, then maybe idle for a burst.
  task automatic offer(logic [1:0] cmd, key_t k, handle_t h);
    in_valid          <= 1'b1;
    in_command        <= cmd;
    in_key_bytes_low  <= k[63:0];
    in_key_bytes_mid  <= k[127:64];
    in_key_bytes_high <= k[KEY_W-1:128];
    in_handle_in      <= h;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_n++;
    cmd_seen[cmd]++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic run_phase(int n, int w_ins, int w_look, int w_rem);
    int         roll;
    logic [1:0] cmd;
    key_t       k;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < w_ins) cmd = CMD_INSERT;
      else if (roll < w_ins + w_look) cmd = CMD_LOOKUP;
      else if (roll < w_ins + w_look + w_rem) cmd = CMD_REMOVE;
      else cmd = CMD_SPARE;
      // stored names come from the pool so that removes can drain the table
      if (cmd != CMD_INSERT && $urandom_range(0, 7) == 0) begin
        k = {24'($urandom), $urandom, $urandom, $urandom, $urandom};
      end else begin
        k = pick_name();
      end
      offer(cmd, k, handle_t'($urandom));
    end
  endtask

  // Hold the sender until every reply has come back.
  task automatic drain_replies();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    key_t name_a;
    key_t name_near;
    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_command        <= CMD_INSERT;
    in_key_bytes_low  <= '0;
    in_key_bytes_mid  <= '0;
    in_key_bytes_high <= '0;
    in_handle_in      <= '0;
    for (int c = 0; c < 4; c++) cmd_seen[c] = 0;
    for (int p = 0; p < POOL_N; p++) begin
      pool_len[p] = $urandom_range(1, KEY_BYTES);
      pool_key[p] = '0;
      for (int b = 0; b < pool_len[p]; b++) pool_key[p][8*b +: 8] = 8'($urandom_range(1, 255));
    end
    // full-length all-ones name, the empty name, and a prefix of a longer name
    pool_len[0] = KEY_BYTES;
    pool_key[0] = '1;
    pool_len[1] = 0;
    pool_key[1] = '0;
    pool_len[3] = KEY_BYTES;
    pool_len[2] = 12;
    pool_key[2] = '0;
    for (int b = 0; b < KEY_BYTES; b++) begin
      pool_key[3][8*b +: 8] = 8'($urandom_range(1, 255));
      if (b < 12) pool_key[2][8*b +: 8] = pool_key[3][8*b +: 8];
    end
    name_a       = '0;
    name_a[7:0]  = 8'h41;
    name_near    = '1;
    name_near[8*(KEY_BYTES-1) +: 8] = 8'hFE;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    offer(CMD_LOOKUP, '0, 16'h0000);
    offer(CMD_REMOVE, with_garbage(name_a, 1), 16'hFFFF);
    offer(CMD_INSERT, '1, 16'hFFFF);
    offer(CMD_INSERT, '0, 16'h0000);
    offer(CMD_INSERT, with_garbage(name_a, 1), 16'h1234);
    offer(CMD_LOOKUP, with_garbage(name_a, 1), 16'hFFFF);
    offer(CMD_LOOKUP, '1, 16'h0000);
    offer(CMD_LOOKUP, '0, 16'h5555);
    offer(CMD_LOOKUP, name_near, 16'h0000);
    offer(CMD_INSERT, name_a, 16'h5678);
    offer(CMD_LOOKUP, name_a, 16'h0000);
    offer(CMD_REMOVE, with_garbage(name_a, 1), 16'h0000);
    offer(CMD_LOOKUP, name_a, 16'h0000);
    offer(CMD_SPARE, {24'($urandom), $urandom, $urandom, $urandom, $urandom}, 16'hFFFF);
    offer(CMD_REMOVE, '1, 16'h0000);
    offer(CMD_REMOVE, '0, 16'h0000);
    offer(CMD_REMOVE, name_a, 16'h0000);
    offer(CMD_LOOKUP, name_a, 16'h0000);
    offer(CMD_INSERT, with_garbage('0, 0), 16'hAAAA);
    offer(CMD_LOOKUP, '0, 16'h0000);
    offer(CMD_REMOVE, with_garbage('0, 0), 16'h0000);

    // fill past capacity, churn, drain, churn again, run remove-heavy, then run without idling
    run_phase(220, 75, 22, 0);
    run_phase(100, 35, 35, 27);
    drain_replies();
    run_phase(100, 35, 35, 27);
    run_phase(220, 10, 20, 67);
    quiet = 1'b1;
    run_phase(80, 40, 30, 27);
    drain_replies();
    repeat (TABLE_DEPTH + 10) @(posedge clk);

    $display("Sent %0d requests: %0d inserts, %0d lookups, %0d removes, %0d unused codes.",
             sent_n, cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3]);
    $display("Table peaked at %0d records; %0d full-table and %0d absent-name replies.",
             peak_fill, full_replies, absent_replies);
    if (fail_count == 0) begin
      $display("tb_ordered_name_to_handle_table: PASS");
    end else begin
      $display("tb_ordered_name_to_handle_table: FAIL");
    end
    $finish;
  end

  // Receiver: short stall bursts, one long hold-off mid-run, none at the end.
  initial begin
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!hold_done && sent_n >= HOLD_AT) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  initial begin
    #6_000_000;
    $display("Run timed out with %0d replies outstanding", outstanding);
    $display("tb_ordered_name_to_handle_table: FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/onht_pkg.sv
hw/rtl/ordered_name_to_handle_table.sv
hw/rtl/onht_checker.sv
tb/onht_reply_checker.sv
tb/tb_ordered_name_to_handle_table.sv
